[src/assert_macros.svh]
// shared assertion macros for the converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under the block reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("converter assertion failed");

// next-cycle implication under the block reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("converter assertion failed");

`endif

[src/itop_pkg.sv]
`timescale 1ns / 1ps
package itop_pkg;

	// payload field widths
	localparam int TAG_W    = 8;
	localparam int PRIO_W   = 4;
	localparam int ARITY_W  = 2;
	localparam int OPND_W   = 32;
	localparam int STATUS_W = 2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY_CLOSE = 2'd2;

	// arity of a unary function
	localparam logic [ARITY_W-1:0] ARITY_FUNC = 2'd1;

	// one postfix result before its last-of-run mark is known
	typedef struct packed {
		logic                is_op;
		logic [TAG_W-1:0]    tag;
		logic [ARITY_W-1:0]  arity;
		logic [OPND_W-1:0]   bits;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

[src/itop_infix_if.sv]
`timescale 1ns / 1ps
interface itop_infix_if;
	import itop_pkg::*;

	logic                valid;
	logic                ready;
	logic                is_operator;
	logic [TAG_W-1:0]    token_tag;
	logic                is_close_paren;
	logic [PRIO_W-1:0]   incoming_priority;
	logic [PRIO_W-1:0]   stacked_priority;
	logic [ARITY_W-1:0]  arity;
	logic [OPND_W-1:0]   operand_bits;
	logic                end_of_expression;

	modport source (
		output valid, is_operator, token_tag, is_close_paren, incoming_priority,
			stacked_priority, arity, operand_bits, end_of_expression,
		input  ready
	);

	modport sink (
		input  valid, is_operator, token_tag, is_close_paren, incoming_priority,
			stacked_priority, arity, operand_bits, end_of_expression,
		output ready
	);

endinterface

[src/itop_postfix_if.sv]
`timescale 1ns / 1ps
interface itop_postfix_if;
	import itop_pkg::*;

	logic                valid;
	logic                ready;
	logic                out_is_operator;
	logic [TAG_W-1:0]    out_token_tag;
	logic [ARITY_W-1:0]  out_arity;
	logic [OPND_W-1:0]   out_operand_bits;
	logic [STATUS_W-1:0] status;
	logic                last_of_run;

	modport source (
		output valid, out_is_operator, out_token_tag, out_arity, out_operand_bits,
			status, last_of_run,
		input  ready
	);

	modport sink (
		input  valid, out_is_operator, out_token_tag, out_arity, out_operand_bits,
			status, last_of_run,
		output ready
	);

endinterface

[src/itop_stack_ram.sv]
`timescale 1ns / 1ps
module itop_stack_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/infix_to_postfix_converter.sv]
`timescale 1ns / 1ps
// shunting-yard infix to postfix converter
// infix: sink channel, one infix token per request (operand or operator/paren)
// postfix: source channel, one postfix token or status word per request;
//   last_of_run marks the final request caused by one infix token
// an operand is forwarded; an operator pops stacked entries of higher or equal
//   stacked priority, then is pushed (overflow status if full); a close paren
//   pops the same way, drops the top entry (empty-close status if none) and pops
//   a unary function found below it; end_of_expression flushes the whole stack
//   after the token is handled
// the operator stack lives in a single-port-write, registered-read ram; each
//   look at the top of stack takes a read state, then a decide state
// a token is taken only while the sequencer is idle; results are held back in a
//   pending register until the end of the run is known
// a stalled receiver stalls the sequencer at its next emitting step
// reset clears the stack count and all valid flags; ram contents are not
//   cleared and are never read at or above the count
`include "assert_macros.svh"
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32,
	parameter int TAG_WIDTH   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	itop_infix_if.sink            infix,
	itop_postfix_if.source        postfix
);
	import itop_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int ENT_W = TAG_WIDTH + ARITY_W + PRIO_W;

	// sequencer states: read the top entry, then decide on it
	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_POP_RD    = 8'b0000_0010,
		S_POP_CMP   = 8'b0000_0100,
		S_FUNC_RD   = 8'b0000_1000,
		S_FUNC_CMP  = 8'b0001_0000,
		S_FLUSH_RD  = 8'b0010_0000,
		S_FLUSH_CMP = 8'b0100_0000,
		S_FIN       = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;

	// latched infix token
	logic                 tok_close_q;
	logic [PRIO_W-1:0]    tok_inc_q;
	logic [PRIO_W-1:0]    tok_stk_q;
	logic [ARITY_W-1:0]   tok_arity_q;
	logic [TAG_WIDTH-1:0] tok_tag_q;
	logic                 tok_eoe_q;
	logic [TAG_WIDTH+TAG_W-1:0] tag_in_ext;

	// stack ram port
	logic             mem_we, mem_re;
	logic [ENT_W-1:0] mem_rdata;

	// top-of-stack fields
	logic [PRIO_W-1:0]          top_prio;
	logic [ARITY_W-1:0]         top_arity;
	logic [TAG_WIDTH-1:0]       top_tag;
	logic [TAG_WIDTH+TAG_W-1:0] top_tag_ext;
	result_t                    pop_res;

	// pending result and output register
	result_t pend_q;
	logic    pend_vld_q;
	result_t out_q;
	logic    out_last_q;
	logic    out_vld_q;
	logic    out_free, go;
	logic    emit, finish, accept;
	result_t emit_res;

	// action once the pops for the current operator are done
	state_t     post_state, eoe_next;
	logic       post_emit, post_push;
	result_t    post_res;
	logic [CNT_W-1:0] post_cnt;

	assign accept     = infix.valid && infix.ready;
	assign infix.ready = (state_q == S_IDLE);
	assign cnt_m1     = cnt_q - 1'b1;
	assign out_free   = !out_vld_q || postfix.ready;
	// a step that may hand the pending result on needs room downstream
	assign go         = out_free || !pend_vld_q;

	assign tag_in_ext = {{TAG_WIDTH{1'b0}}, infix.token_tag};

	assign top_prio    = mem_rdata[PRIO_W-1:0];
	assign top_arity   = mem_rdata[PRIO_W +: ARITY_W];
	assign top_tag     = mem_rdata[PRIO_W + ARITY_W +: TAG_WIDTH];
	assign top_tag_ext = {{TAG_W{1'b0}}, top_tag};

	always_comb begin
		pop_res        = '0;
		pop_res.is_op  = 1'b1;
		pop_res.tag    = top_tag_ext[TAG_W-1:0];
		pop_res.arity  = top_arity;
		pop_res.status = ST_OK;
	end

	itop_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (ENT_W)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({tok_tag_q, tok_arity_q, tok_stk_q}),
		.re    (mem_re),
		.raddr (cnt_m1[AW-1:0]),
		.rdata (mem_rdata)
	);

	always_comb begin
		eoe_next   = tok_eoe_q ? S_FLUSH_RD : S_FIN;
		post_state = eoe_next;
		post_emit  = 1'b0;
		post_push  = 1'b0;
		post_res   = '0;
		post_cnt   = cnt_q;
		if (tok_close_q) begin
			if (cnt_q == '0) begin
				// close paren with nothing left to match
				post_emit       = 1'b1;
				post_res.status = ST_EMPTY_CLOSE;
			end else begin
				// drop the matching open paren, then look for a function
				post_cnt   = cnt_m1;
				post_state = S_FUNC_RD;
			end
		end else if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
			post_emit       = 1'b1;
			post_res.status = ST_OVERFLOW;
		end else begin
			post_push = 1'b1;
			post_cnt  = cnt_q + 1'b1;
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		emit     = 1'b0;
		emit_res = pop_res;
		finish   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!infix.is_operator) begin
						// operand goes straight to the pending slot
						emit          = 1'b1;
						emit_res      = '0;
						emit_res.bits = infix.operand_bits;
						state_d       = infix.end_of_expression ? S_FLUSH_RD : S_FIN;
					end else begin
						state_d = S_POP_RD;
					end
				end
			end
			S_POP_RD: begin
				if (cnt_q != '0) begin
					mem_re  = 1'b1;
					state_d = S_POP_CMP;
				end else if (go) begin
					emit     = post_emit;
					emit_res = post_res;
					mem_we   = post_push;
					cnt_d    = post_cnt;
					state_d  = post_state;
				end
			end
			S_POP_CMP: begin
				if (go) begin
					if (top_prio >= tok_inc_q) begin
						emit    = 1'b1;
						cnt_d   = cnt_m1;
						state_d = S_POP_RD;
					end else begin
						emit     = post_emit;
						emit_res = post_res;
						mem_we   = post_push;
						cnt_d    = post_cnt;
						state_d  = post_state;
					end
				end
			end
			S_FUNC_RD: begin
				if (cnt_q != '0) begin
					mem_re  = 1'b1;
					state_d = S_FUNC_CMP;
				end else begin
					state_d = eoe_next;
				end
			end
			S_FUNC_CMP: begin
				if (go) begin
					if (top_arity == ARITY_FUNC) begin
						emit  = 1'b1;
						cnt_d = cnt_m1;
					end
					state_d = eoe_next;
				end
			end
			S_FLUSH_RD: begin
				if (cnt_q != '0) begin
					mem_re  = 1'b1;
					state_d = S_FLUSH_CMP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FLUSH_CMP: begin
				if (go) begin
					emit    = 1'b1;
					cnt_d   = cnt_m1;
					state_d = S_FLUSH_RD;
				end
			end
			S_FIN: begin
				if (!pend_vld_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_close_q <= infix.is_close_paren;
			tok_inc_q   <= infix.incoming_priority;
			tok_stk_q   <= infix.stacked_priority;
			tok_arity_q <= infix.arity;
			tok_tag_q   <= tag_in_ext[TAG_WIDTH-1:0];
			tok_eoe_q   <= infix.end_of_expression;
		end
	end

	// pending slot and output register valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (emit) begin
				pend_vld_q <= 1'b1;
			end else if (finish) begin
				pend_vld_q <= 1'b0;
			end
			if ((emit && pend_vld_q) || finish) begin
				out_vld_q <= 1'b1;
			end else if (postfix.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q <= emit_res;
		end
		if ((emit && pend_vld_q) || finish) begin
			out_q      <= pend_q;
			out_last_q <= finish;
		end
	end

	assign postfix.valid            = out_vld_q;
	assign postfix.out_is_operator  = out_q.is_op;
	assign postfix.out_token_tag    = out_q.tag;
	assign postfix.out_arity        = out_q.arity;
	assign postfix.out_operand_bits = out_q.bits;
	assign postfix.status           = out_q.status;
	assign postfix.last_of_run      = out_last_q;

	// count stays within the stack
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH))
	// no push onto a full stack
	`ASSERT_IMPL(a_no_overflow_push, clk, arst_n, mem_we, cnt_q < CNT_W'(STACK_DEPTH))
	// only live entries are read
	`ASSERT_IMPL(a_read_live, clk, arst_n, mem_re, cnt_q != '0)
	// a new token never meets a leftover pending result
	`ASSERT_IMPL(a_idle_clean, clk, arst_n, state_q == S_IDLE, !pend_vld_q)
	// a pending result is never overwritten while the output is blocked
	`ASSERT_IMPL(a_emit_room, clk, arst_n, emit && pend_vld_q, out_free)
	// the run's last result leaves the pending slot empty
	`ASSERT_NEXT(a_finish_clears, clk, arst_n, finish, !pend_vld_q && out_vld_q)

endmodule
